### rtl/dsrt_pkg.sv
// ----------------------------------------------------------------------------
// dsrt_pkg
// shared constants for the dual sensor range and crossing tracker
// ----------------------------------------------------------------------------
package dsrt_pkg;

  // configuration register map
  localparam int CFG_INDEX_BITS = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_UPPER_THRESHOLD = 1'b0,
    REG_LOWER_THRESHOLD = 1'b1
  } cfg_reg_t;

  // threshold values after reset
  localparam int UPPER_THRESHOLD_RESET = 700;
  localparam int LOWER_THRESHOLD_RESET = 300;

  // completion test on crossing counts
  localparam int DONE_MIN_CROSSINGS = 3;
  localparam int DONE_MIN_LEAD      = 1;

endpackage

### rtl/dsrt_in_if.sv
// ----------------------------------------------------------------------------
// dsrt_in_if
// sample channel: start request and one reading from each sensor
// ----------------------------------------------------------------------------
interface dsrt_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   start_req;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output start_req, output left_sample,
                  output right_sample, input ready);
  modport sink   (input valid, input start_req, input left_sample,
                  input right_sample, output ready);
endinterface

### rtl/dsrt_out_if.sv
// ----------------------------------------------------------------------------
// dsrt_out_if
// result channel: ranges, on-line flags and completion
// ----------------------------------------------------------------------------
interface dsrt_out_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_low;
  logic [SAMPLE_BITS-1:0] left_high;
  logic [SAMPLE_BITS-1:0] right_low;
  logic [SAMPLE_BITS-1:0] right_high;
  logic                   left_on;
  logic                   right_on;
  logic                   calibration_done;

  modport source (output valid, output left_low, output left_high, output right_low,
                  output right_high, output left_on, output right_on,
                  output calibration_done, input ready);
  modport sink   (input valid, input left_low, input left_high, input right_low,
                  input right_high, input left_on, input right_on,
                  input calibration_done, output ready);
endinterface

### rtl/dsrt_chan.sv
// ----------------------------------------------------------------------------
// dsrt_chan
// one sensor: range tracking, hysteresis flag and saturating crossing count
// ----------------------------------------------------------------------------
module dsrt_chan #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] upper_threshold,
  input  logic [SAMPLE_BITS-1:0] lower_threshold,
  output logic [SAMPLE_BITS-1:0] lo_next,
  output logic [SAMPLE_BITS-1:0] hi_next,
  output logic                   on_next,
  output logic [COUNT_BITS-1:0]  count_next
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [SAMPLE_BITS-1:0] lo;
  logic [SAMPLE_BITS-1:0] hi;
  logic                   on;
  logic [COUNT_BITS-1:0]  count;

  logic on_set;
  logic off_hit;

  always_comb begin
    on_set  = on | (sample >= upper_threshold);
    off_hit = on_set & (sample <= lower_threshold);
    if (start) begin
      lo_next    = sample;
      hi_next    = sample;
      on_next    = 1'b0;
      count_next = '0;
    end else begin
      lo_next    = (sample < lo) ? sample : lo;
      hi_next    = (sample > hi) ? sample : hi;
      on_next    = on_set & ~off_hit;
      count_next = (off_hit && count != COUNT_MAX) ? count + 1'b1 : count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo    <= '0;
      hi    <= '0;
      on    <= 1'b0;
      count <= '0;
    end else if (advance) begin
      lo    <= lo_next;
      hi    <= hi_next;
      on    <= on_next;
      count <= count_next;
    end
  end

endmodule

### rtl/dual_sensor_range_and_crossing_tracker.sv
// ----------------------------------------------------------------------------
// dual_sensor_range_and_crossing_tracker
// min/max tracking and hysteresis crossing counts for two line sensors
// ----------------------------------------------------------------------------
// usage
//   samples: one transaction per pair of readings; start_req seeds both ranges
//     from the readings and clears flags and crossing counts
//   results: one transaction per sample transaction, in order
//   cfg_we/cfg_index/cfg_data: threshold writes, only while the block is idle
// output: results are registered, into the skid slot while the output waits
// throughput: one sample per cycle while ready is high; the state update is
//   a single compare and increment pass per sensor between the state
//   registers and the result register
// reset: thresholds return to 700/300, ranges, flags and counts to zero, and
//   both result slots empty
// stall: a two-slot result buffer (output register plus skid register) lets
//   one more sample in while a result waits; ready drops once both are full
// ----------------------------------------------------------------------------
module dual_sensor_range_and_crossing_tracker #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  dsrt_in_if.sink                            samples,
  dsrt_out_if.source                         results,
  input  logic                               cfg_we,
  input  logic [dsrt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]             cfg_data
);

  // completion constants at counter width plus one guard bit
  localparam logic [COUNT_BITS:0] MIN_CROSS = (COUNT_BITS + 1)'(dsrt_pkg::DONE_MIN_CROSSINGS);
  localparam logic [COUNT_BITS:0] MIN_LEAD  = (COUNT_BITS + 1)'(dsrt_pkg::DONE_MIN_LEAD);

  // configuration registers
  logic [SAMPLE_BITS-1:0] upper_threshold;
  logic [SAMPLE_BITS-1:0] lower_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_threshold <= SAMPLE_BITS'(dsrt_pkg::UPPER_THRESHOLD_RESET);
      lower_threshold <= SAMPLE_BITS'(dsrt_pkg::LOWER_THRESHOLD_RESET);
    end else if (cfg_we) begin
      unique case (dsrt_pkg::cfg_reg_t'(cfg_index))
        dsrt_pkg::REG_UPPER_THRESHOLD: upper_threshold <= cfg_data;
        dsrt_pkg::REG_LOWER_THRESHOLD: lower_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic skid_valid;
  logic accept;
  logic out_fire;

  assign samples.ready = ~skid_valid;
  assign accept        = samples.valid & samples.ready;
  assign out_fire      = results.valid & results.ready;

  // per-sensor trackers, state advances on each accepted sample
  logic [SAMPLE_BITS-1:0] l_lo, l_hi, r_lo, r_hi;
  logic                   l_on, r_on;
  logic [COUNT_BITS-1:0]  l_count, r_count;

  dsrt_chan #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_left (
    .clk             (clk),
    .rst             (rst),
    .advance         (accept),
    .start           (samples.start_req),
    .sample          (samples.left_sample),
    .upper_threshold (upper_threshold),
    .lower_threshold (lower_threshold),
    .lo_next         (l_lo),
    .hi_next         (l_hi),
    .on_next         (l_on),
    .count_next      (l_count)
  );

  dsrt_chan #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_right (
    .clk             (clk),
    .rst             (rst),
    .advance         (accept),
    .start           (samples.start_req),
    .sample          (samples.right_sample),
    .upper_threshold (upper_threshold),
    .lower_threshold (lower_threshold),
    .lo_next         (r_lo),
    .hi_next         (r_hi),
    .on_next         (r_on),
    .count_next      (r_count)
  );

  // done: never on a start, else left at least the minimum and left minus right
  // above the lead, compared one bit wider so right plus the lead cannot wrap
  logic [COUNT_BITS:0] l_wide;
  logic [COUNT_BITS:0] r_wide;
  logic                done;

  assign l_wide = {1'b0, l_count};
  assign r_wide = {1'b0, r_count};
  assign done   = ~samples.start_req & (l_wide >= MIN_CROSS) & (l_wide > r_wide + MIN_LEAD);

  // result buffer: output register and skid register
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_l_lo, out_l_hi, out_r_lo, out_r_hi;
  logic                   out_l_on, out_r_on, out_done;
  logic [SAMPLE_BITS-1:0] skid_l_lo, skid_l_hi, skid_r_lo, skid_r_hi;
  logic                   skid_l_on, skid_r_on, skid_done;
  logic                   load_out;
  logic                   load_skid;

  assign load_out  = accept & (~out_valid | out_fire);
  assign load_skid = accept & out_valid & ~out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= skid_valid;
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_l_lo <= l_lo;
      out_l_hi <= l_hi;
      out_r_lo <= r_lo;
      out_r_hi <= r_hi;
      out_l_on <= l_on;
      out_r_on <= r_on;
      out_done <= done;
    end else if (out_fire && skid_valid) begin
      // drain the waiting transaction into the output slot
      out_l_lo <= skid_l_lo;
      out_l_hi <= skid_l_hi;
      out_r_lo <= skid_r_lo;
      out_r_hi <= skid_r_hi;
      out_l_on <= skid_l_on;
      out_r_on <= skid_r_on;
      out_done <= skid_done;
    end
    if (load_skid) begin
      skid_l_lo <= l_lo;
      skid_l_hi <= l_hi;
      skid_r_lo <= r_lo;
      skid_r_hi <= r_hi;
      skid_l_on <= l_on;
      skid_r_on <= r_on;
      skid_done <= done;
    end
  end

  assign results.valid            = out_valid;
  assign results.left_low         = out_l_lo;
  assign results.left_high        = out_l_hi;
  assign results.right_low        = out_r_lo;
  assign results.right_high       = out_r_hi;
  assign results.left_on          = out_l_on;
  assign results.right_on         = out_r_on;
  assign results.calibration_done = out_done;

`ifndef ASSERT_OFF
  // skid slot only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a transaction with the output slot empty");

  // a sample taken while the output stalls must land in the skid slot
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !results.ready) |=> skid_valid)
    else $error("sample accepted during stall was not buffered");

  // a start result shows cleared flags and no completion
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && samples.start_req && (!out_valid || results.ready)) |=>
      (!results.left_on && !results.right_on && !results.calibration_done))
    else $error("start transaction left flags or completion set");
`endif

endmodule
